FILE: rtl/core/wgodo_pkg.sv
// Shared types, constants and helper functions of the odometry integrator.
package wgodo_pkg;

  // Field and port widths.
  localparam int unsigned CountW  = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ThreshW = 15;

  // Iteration counter: wide enough for the longest loop (the divider).
  localparam int unsigned CntW      = 7;
  localparam int unsigned MulDigits = 8;
  localparam int unsigned DivIters  = 64;
  localparam int unsigned AtanN     = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RATE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESH = 2'd2;

  // Register reset values.
  localparam logic [WordW-1:0]   RATE_RESET   = 32'd6553600;
  localparam logic [ThreshW-1:0] THRESH_RESET = 15'd209;

  // Fixed-point constants, Q30 where noted.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0]        PI_Q30      = 32'd3373259426;
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_RAD,
    ST_ARC_COR,
    ST_SIN_DIV,
    ST_SIN_MUL,
    ST_COS_DIV,
    ST_COS_MUL,
    ST_OLD_COR,
    ST_POS_ROT,
    ST_NEW_COR,
    ST_VEL_ROT,
    ST_SCALE,
    ST_OUT
  } wgodo_state_e;

  // Arctangent of 2^-i as a binary angle (2^32 is a full turn).
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Magnitude of a signed 64-bit value.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Saturate a 65-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    logic [31:0] r;
    if (!v[64] && (v[63:31] != '0)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[64] && (v[63:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/wgodo_if.sv
// Channel interfaces of the odometry integrator: configuration, sample in, result out.
interface wgodo_cfg_if import wgodo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface wgodo_in_if import wgodo_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] left_count;
  logic signed [CountW-1:0] right_count;
  logic signed [CountW-1:0] heading_step;

  modport source (output valid, left_count, right_count, heading_step, input ready);
  modport sink   (input valid, left_count, right_count, heading_step, output ready);
endinterface

interface wgodo_out_if import wgodo_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] pos_x;
  logic signed [WordW-1:0] pos_y;
  logic        [WordW-1:0] heading;
  logic signed [WordW-1:0] vel_x;
  logic signed [WordW-1:0] vel_y;

  modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, vel_x, vel_y, output ready);
endinterface

FILE: rtl/core/wheel_gyro_odometry_integrator.sv
// Top level of the wheel and gyro dead-reckoning odometry integrator.
//
//  Channel    Direction  Payload                                      Beat when
//  cfg_ch_i   in         index, data                                  valid & ready
//  in_ch_i    in         left_count, right_count, heading_step        valid & ready
//  out_ch_o   out        pos_x, pos_y, heading, vel_x, vel_y          valid & ready
//
// A sample takes longer on an arc than on a straight step, plus any stall on the output.
// The time is set by the shared 64x8 digit multiplier, the one-bit-per-cycle divider and
// the one-step-per-cycle CORDIC. Reset clears position and heading and sets the
// configuration registers to their reset values; the block then takes samples at once.
// A sample is taken only in idle; the result is held until the output beat completes.
// The configuration port is always ready.
module wheel_gyro_odometry_integrator import wgodo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wgodo_cfg_if.sink    cfg_ch_i,
  wgodo_in_if.sink     in_ch_i,
  wgodo_out_if.source  out_ch_o
);

  localparam logic [CntW-1:0] CordLast = CntW'(CORDIC_STEPS - 1);
  localparam logic [CntW-1:0] MulLast  = CntW'(MulDigits - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(DivIters - 1);

  // Control state.
  wgodo_state_e      state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        k_q, k_d;

  // Configuration registers.
  logic [WordW-1:0]   scale_q, rate_q;
  logic [ThreshW-1:0] thr_q;

  // Architectural state and results.
  logic [WordW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, head_q, head_d;
  logic [WordW-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;

  // Datapath holding registers.
  logic signed [16:0] sum_q, sum_d;
  logic signed [15:0] step_q, step_d;
  logic signed [63:0] dist_q, dist_d, dx_q, dx_d, dy_q, dy_d, rx_q, rx_d, ry_q, ry_d;
  logic [63:0]        fac_q, fac_d;
  logic [31:0]        rad_q, rad_d;
  logic signed [33:0] c_q, c_d, s_q, s_d;

  // Iterative unit registers.
  logic [127:0]       acc_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [31:0]        rem_q;
  logic [63:0]        quo_q;

  // Sample decode.
  logic [15:0] step_mag;
  logic [16:0] sum_mag;
  logic        straight;

  assign step_mag = step_q[15] ? 16'(-step_q) : 16'(step_q);
  assign sum_mag  = sum_q[16] ? 17'(-sum_q) : 17'(sum_q);
  assign straight = (step_mag == 16'd0) || (step_mag < {1'b0, thr_q});

  // Rotation operand selection: c*dx, s*dy, s*dx, c*dy.
  logic signed [63:0] rot_l, rot_r;
  assign rot_l = (k_q[0] ^ k_q[1]) ? {{30{s_q[33]}}, s_q} : {{30{c_q[33]}}, c_q};
  assign rot_r = k_q[0] ? dy_q : dx_q;

  // Shared multiplier operands and product sign.
  logic [63:0] mul_a, mul_b;
  logic        mul_neg;

  always_comb begin
    mul_a   = mag64(rot_l);
    mul_b   = mag64(rot_r);
    mul_neg = rot_l[63] ^ rot_r[63];
    case (state_q)
      ST_DIST: begin
        mul_a   = 64'(sum_mag);
        mul_b   = 64'(scale_q);
        mul_neg = sum_q[16];
      end
      ST_RAD: begin
        mul_a   = 64'(step_mag);
        mul_b   = 64'(PI_Q30);
        mul_neg = 1'b0;
      end
      ST_SIN_MUL: begin
        mul_a   = mag64(dist_q);
        mul_b   = fac_q;
        mul_neg = dist_q[63];
      end
      ST_COS_MUL: begin
        mul_a   = mag64(dist_q);
        mul_b   = fac_q;
        mul_neg = dist_q[63] ^ step_q[15];
      end
      ST_SCALE: begin
        mul_a   = k_q[0] ? mag64(ry_q) : mag64(rx_q);
        mul_b   = 64'(rate_q);
        mul_neg = k_q[0] ? ry_q[63] : rx_q[63];
      end
      default: begin
      end
    endcase
  end

  // Digit-serial multiply, most significant 8-bit digit of mul_b first.
  logic [7:0]   mul_dig;
  logic [71:0]  mul_part;
  logic [127:0] prod_w;

  assign mul_dig  = mul_b[{~cnt_q[2:0], 3'b000} +: 8];
  assign mul_part = mul_a * mul_dig;
  assign prod_w   = ((cnt_q == '0) ? 128'd0 : {acc_q[119:0], 8'd0}) + {56'd0, mul_part};

  // Product post-processing: Q30 rounding, distance rounding, rate scaling.
  logic [127:0]       prod_r30, prod_r16;
  logic [63:0]        q30_mag;
  logic signed [63:0] q30_val;
  logic [32:0]        dq;
  logic signed [63:0] dist_new;
  logic [31:0]        vel_val;
  logic               vel_big;

  assign prod_r30 = prod_w + 128'h2000_0000;
  assign prod_r16 = prod_w + 128'h8000;
  assign q30_mag  = prod_r30[93:30];
  assign q30_val  = mul_neg ? -$signed(q30_mag) : $signed(q30_mag);
  assign dq       = prod_r16[48:16];
  assign dist_new = sum_q[16] ? -$signed({31'd0, dq}) : $signed({31'd0, dq});
  assign vel_big  = (prod_r16[127:47] != '0);

  always_comb begin
    if (mul_neg) begin
      vel_val = vel_big ? 32'h8000_0000 : 32'(-{1'b0, prod_r16[46:16]});
    end else begin
      vel_val = vel_big ? 32'h7FFF_FFFF : {1'b0, prod_r16[46:16]};
    end
  end

  // CORDIC rotation step, angle folded into the right half-plane first.
  logic [31:0]        cor_ang, ang_f;
  logic               flip;
  logic [31:0]        ang_sum;
  logic signed [33:0] cur_x, cur_y, sh_x, sh_y, nx, ny, cos_res, sin_res;
  logic signed [32:0] cur_z, nz, atan_v;
  logic [4:0]         cidx;

  assign cor_ang = (state_q == ST_ARC_COR) ? {step_mag, 16'd0} : head_q;
  assign ang_sum = cor_ang + 32'h4000_0000;
  assign flip    = ang_sum[31];
  assign ang_f   = flip ? (cor_ang ^ 32'h8000_0000) : cor_ang;
  assign cidx    = cnt_q[4:0];
  assign cur_x   = (cnt_q == '0) ? CORDIC_GAIN : cx_q;
  assign cur_y   = (cnt_q == '0) ? 34'sd0 : cy_q;
  assign cur_z   = (cnt_q == '0) ? $signed({ang_f[31], ang_f}) : cz_q;
  assign sh_x    = cur_y >>> cidx;
  assign sh_y    = cur_x >>> cidx;
  assign atan_v  = $signed({1'b0, atan_lut(cidx)});

  always_comb begin
    if (!cur_z[32]) begin
      nx = cur_x - sh_x;
      ny = cur_y + sh_y;
      nz = cur_z - atan_v;
    end else begin
      nx = cur_x + sh_x;
      ny = cur_y - sh_y;
      nz = cur_z + atan_v;
    end
  end

  assign cos_res = flip ? -nx : nx;
  assign sin_res = flip ? -ny : ny;

  // Arc factors: sine clamped at zero, one minus cosine clamped at zero.
  logic signed [34:0] omc;
  assign omc = ONE_Q30 - {cos_res[33], cos_res};

  // Restoring divider, one quotient bit per cycle.
  logic [63:0] div_num;
  logic        div_bit;
  logic [31:0] rem_cur, rem_next;
  logic [63:0] quo_cur, quo_next;
  logic [32:0] trial;
  logic        div_ge;

  assign div_num  = (state_q == ST_COS_DIV) ? {c_q, 30'd0} : {s_q, 30'd0};
  assign div_bit  = div_num[~cnt_q[5:0]];
  assign rem_cur  = (cnt_q == '0) ? 32'd0 : rem_q;
  assign quo_cur  = (cnt_q == '0) ? 64'd0 : quo_q;
  assign trial    = {rem_cur, div_bit};
  assign div_ge   = (trial >= {1'b0, rad_q});
  assign rem_next = div_ge ? 32'(trial - {1'b0, rad_q}) : trial[31:0];
  assign quo_next = {quo_cur[62:0], div_ge};

  // Position update from the world step.
  logic signed [63:0] ry_fin;
  assign ry_fin = ry_q + q30_val;

  // Sequencer: next state and datapath loads.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    k_d     = k_q;
    sum_d   = sum_q;
    step_d  = step_q;
    dist_d  = dist_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    fac_d   = fac_q;
    rad_d   = rad_q;
    c_d     = c_q;
    s_d     = s_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    head_d  = head_q;
    vel_x_d = vel_x_q;
    vel_y_d = vel_y_q;
    case (state_q)
      ST_IDLE: begin
        if (in_ch_i.valid) begin
          sum_d   = {in_ch_i.left_count[15], in_ch_i.left_count}
                  + {in_ch_i.right_count[15], in_ch_i.right_count};
          step_d  = in_ch_i.heading_step;
          cnt_d   = '0;
          k_d     = 2'd0;
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        if (cnt_q == MulLast) begin
          dist_d = dist_new;
          cnt_d  = '0;
          if (straight) begin
            dx_d    = dist_new;
            dy_d    = 64'sd0;
            state_d = ST_OLD_COR;
          end else begin
            state_d = ST_RAD;
          end
        end
      end
      ST_RAD: begin
        if (cnt_q == MulLast) begin
          rad_d   = prod_w[46:15];
          cnt_d   = '0;
          state_d = ST_ARC_COR;
        end
      end
      ST_ARC_COR: begin
        if (cnt_q == CordLast) begin
          s_d     = sin_res[33] ? 34'sd0 : sin_res;
          c_d     = omc[34] ? 34'sd0 : omc[33:0];
          cnt_d   = '0;
          state_d = ST_SIN_DIV;
        end
      end
      ST_SIN_DIV: begin
        if (cnt_q == DivLast) begin
          fac_d   = quo_next;
          cnt_d   = '0;
          state_d = ST_SIN_MUL;
        end
      end
      ST_SIN_MUL: begin
        if (cnt_q == MulLast) begin
          dx_d    = q30_val;
          cnt_d   = '0;
          state_d = ST_COS_DIV;
        end
      end
      ST_COS_DIV: begin
        if (cnt_q == DivLast) begin
          fac_d   = quo_next;
          cnt_d   = '0;
          state_d = ST_COS_MUL;
        end
      end
      ST_COS_MUL: begin
        if (cnt_q == MulLast) begin
          dy_d    = q30_val;
          cnt_d   = '0;
          state_d = ST_OLD_COR;
        end
      end
      ST_OLD_COR, ST_NEW_COR: begin
        if (cnt_q == CordLast) begin
          c_d     = cos_res;
          s_d     = sin_res;
          cnt_d   = '0;
          state_d = (state_q == ST_OLD_COR) ? ST_POS_ROT : ST_VEL_ROT;
        end
      end
      ST_POS_ROT, ST_VEL_ROT: begin
        if (cnt_q == MulLast) begin
          cnt_d = '0;
          k_d   = k_q + 1'b1;
          case (k_q)
            2'd0: rx_d = q30_val;
            2'd1: rx_d = rx_q - q30_val;
            2'd2: ry_d = q30_val;
            default: begin
              ry_d = ry_fin;
              if (state_q == ST_POS_ROT) begin
                pos_x_d = sat32({{33{pos_x_q[31]}}, pos_x_q} + {rx_q[63], rx_q});
                pos_y_d = sat32({{33{pos_y_q[31]}}, pos_y_q} + {ry_fin[63], ry_fin});
                head_d  = head_q + {step_q, 16'd0};
                state_d = ST_NEW_COR;
              end else begin
                state_d = ST_SCALE;
              end
            end
          endcase
        end
      end
      ST_SCALE: begin
        if (cnt_q == MulLast) begin
          cnt_d = '0;
          if (k_q[0]) begin
            vel_y_d = vel_val;
            k_d     = 2'd0;
            state_d = ST_OUT;
          end else begin
            vel_x_d = vel_val;
            k_d     = 2'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_ch_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= 2'd0;
      scale_q <= '0;
      rate_q  <= RATE_RESET;
      thr_q   <= THRESH_RESET;
      pos_x_q <= '0;
      pos_y_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      head_q  <= head_d;
      if (cfg_ch_i.valid) begin
        case (cfg_ch_i.index)
          REG_SCALE:  scale_q <= cfg_ch_i.data;
          REG_RATE:   rate_q  <= cfg_ch_i.data;
          REG_THRESH: thr_q   <= cfg_ch_i.data[ThreshW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    step_q  <= step_d;
    dist_q  <= dist_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    fac_q   <= fac_d;
    rad_q   <= rad_d;
    c_q     <= c_d;
    s_q     <= s_d;
    vel_x_q <= vel_x_d;
    vel_y_q <= vel_y_d;
    acc_q   <= prod_w;
    cx_q    <= nx;
    cy_q    <= ny;
    cz_q    <= nz;
    rem_q   <= rem_next;
    quo_q   <= quo_next;
  end

  // Handshakes and result payload.
  assign cfg_ch_i.ready = 1'b1;
  assign in_ch_i.ready  = (state_q == ST_IDLE);
  assign out_ch_o.valid = (state_q == ST_OUT);
  assign out_ch_o.pos_x   = pos_x_q;
  assign out_ch_o.pos_y   = pos_y_q;
  assign out_ch_o.heading = head_q;
  assign out_ch_o.vel_x   = vel_x_q;
  assign out_ch_o.vel_y   = vel_y_q;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the wheel and gyro odometry integrator.
module tb;
  import wgodo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Arctangent of 2^-i as a binary angle, one entry per rotation step.
  localparam int NumSteps = 16;
  localparam longint AtanTurn [NumSteps] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };
  localparam longint GainQ30 = 652032874;
  localparam longint OneQ30 = 1073741824;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } odo_result_t;

  // Pose tracker: keeps its own pose and registers and queues the expected poses.
  class pose_tracker;
    longint unsigned scale, rate, thresh;
    longint px, py;
    logic [31:0] hdg;
    odo_result_t pending[$];
    int mismatches, checked, n_arc, n_straight;

    function new();
      scale = 0;
      rate = RATE_RESET;
      thresh = THRESH_RESET;
      px = 0;
      py = 0;
      hdg = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_SCALE:  scale = val;
        REG_RATE:   rate = val;
        REG_THRESH: thresh = val[ThreshW-1:0];
        default: ;
      endcase
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // Rounded Q30 product, formed on magnitudes.
    static function longint qmul(longint a, longint f);
      longint unsigned p;
      p = (mag(a) * mag(f) + 64'd536870912) >> 30;
      return ((a < 0) != (f < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Cosine and sine of a binary angle by vector rotation, folded by a half turn.
    static function void sincos(logic [31:0] ang, output longint c, output longint s);
      logic flip;
      longint x, y, z, tx;
      flip = ang[31] ^ ang[30];
      if (flip) ang[31] = ~ang[31];
      z = longint'($signed(ang));
      x = GainQ30;
      y = 0;
      for (int i = 0; i < NumSteps; i++) begin
        tx = x;
        if (z >= 0) begin
          x = x - (y >>> i);
          y = y + (tx >>> i);
          z = z - AtanTurn[i];
        end else begin
          x = x + (y >>> i);
          y = y - (tx >>> i);
          z = z + AtanTurn[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint by_rate(longint v);
      longint unsigned m, p;
      m = mag(v);
      p = m * (rate >> 16) + ((m * (rate & 64'hFFFF) + 64'd32768) >> 16);
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      return clamp32((v < 0) ? -longint'(p) : longint'(p));
    endfunction

    // Advance the pose by one accepted sample and queue the expected result.
    function void note_sample(logic signed [15:0] l, logic signed [15:0] r,
                              logic signed [15:0] h);
      longint sum, dd, travel, dx, dy, c, s, omc, wx, wy;
      longint unsigned a, dq, rad, num;
      odo_result_t e;
      sum = longint'(l) + longint'(r);
      dd = longint'(h);
      a = mag(dd);
      dq = (mag(sum) * scale + 64'd32768) >> 16;
      travel = (sum < 0) ? -longint'(dq) : longint'(dq);
      if (a == 0 || a < thresh) begin
        dx = travel;
        dy = 0;
        n_straight++;
      end else begin
        rad = (a * PiQ30) >> 15;
        sincos(32'(a << 16), c, s);
        if (s < 0) s = 0;
        omc = OneQ30 - c;
        if (omc < 0) omc = 0;
        num = longint'(s) << 30;
        dx = qmul(travel, longint'(num / rad));
        num = longint'(omc) << 30;
        dy = qmul(travel, longint'(num / rad));
        if (dd < 0) dy = -dy;
        n_arc++;
      end
      // Position moves along the old heading.
      sincos(hdg, c, s);
      wx = qmul(c, dx) - qmul(s, dy);
      wy = qmul(s, dx) + qmul(c, dy);
      px = clamp32(px + wx);
      py = clamp32(py + wy);
      hdg = hdg + {h, 16'h0000};
      // Velocity uses the new heading.
      sincos(hdg, c, s);
      e.pos_x = px[31:0];
      e.pos_y = py[31:0];
      e.heading = hdg;
      e.vel_x = 32'(by_rate(qmul(c, dx) - qmul(s, dy)));
      e.vel_y = 32'(by_rate(qmul(s, dx) + qmul(c, dy)));
      pending.push_back(e);
    endfunction

    function void check_result(odo_result_t got);
      odo_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected: %h", got);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pos_x !== e.pos_x || got.pos_y !== e.pos_y || got.heading !== e.heading ||
          got.vel_x !== e.vel_x || got.vel_y !== e.vel_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  pos_x exp %h got %h  pos_y exp %h got %h", e.pos_x, got.pos_x,
                   e.pos_y, got.pos_y);
          $display("  heading exp %h got %h", e.heading, got.heading);
          $display("  vel_x exp %h got %h  vel_y exp %h got %h", e.vel_x, got.vel_x,
                   e.vel_y, got.vel_y);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet = 1'b0;
  int cfg_writes = 0;

  wgodo_cfg_if cfg_ch ();
  wgodo_in_if in_ch ();
  wgodo_out_if out_ch ();

  pose_tracker tracker = new();

  wheel_gyro_odometry_integrator i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_ch_i (cfg_ch),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 6);
  endfunction

  // Result sink: check each beat, stall at random.
  initial out_ch.ready = 1'b1;
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      tracker.check_result('{out_ch.pos_x, out_ch.pos_y, out_ch.heading,
                             out_ch.vel_x, out_ch.vel_y});
    end
    out_ch.ready <= !take_break();
  end

  // One register write, followed by a return to idle on the channel.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.write_reg(idx, val);
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r,
                             logic signed [15:0] h);
    if (take_break()) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.left_count <= l;
    in_ch.right_count <= r;
    in_ch.heading_step <= h;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_sample(l, r, h);
  endtask

  // Let every expected pose arrive before touching the registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_count();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 16'($signed($urandom_range(0, 400)) - 200);
    if (sel < 90) return 16'($urandom);
    return sel[0] ? 16'h7FFF : 16'h8000;
  endfunction

  function automatic logic [15:0] rand_step();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 16'($signed($urandom_range(0, 800)) - 400);
    if (sel < 80) return 16'($urandom);
    if (sel < 90) return 16'h0000;
    return (sel < 95) ? 16'h8000 : 16'h7FFF;
  endfunction

  logic [31:0] phase_scale [5] = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0000_4000};
  logic [31:0] phase_rate [5] = '{RATE_RESET, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0064_0000};
  logic [31:0] phase_thr [5] = '{32'd209, 32'h7FFF, 32'h0, 32'h0, 32'd1};

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.left_count = '0;
    in_ch.right_count = '0;
    in_ch.heading_step = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples on the reset threshold and rate, then on a zero threshold and after a spare-index write.
    write_reg(REG_SCALE, 32'h0100_0000);
    send_sample(16'sd100, 16'sd100, 16'sd0);
    send_sample(16'sd32767, 16'sd32767, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, 16'sd100);
    send_sample(16'sd50, 16'sd70, 16'sd208);
    send_sample(16'sd50, 16'sd70, 16'sd209);
    send_sample(16'sd50, 16'sd70, -16'sd209);
    send_sample(16'sd500, 16'sd300, 16'sd16384);
    send_sample(16'sd500, 16'sd300, -16'sd32768);
    send_sample(16'sd500, 16'sd300, 16'sd32767);
    send_sample(-16'sd400, 16'sd10, -16'sd12000);
    send_sample(16'sd0, 16'sd0, 16'sd5000);
    send_sample(16'hFFFF, 16'h5555, 16'hAAAA);
    drain();
    write_reg(REG_THRESH, 32'hFFFF_0000);
    send_sample(16'sd20, 16'sd20, 16'sd0);
    send_sample(16'sd20, 16'sd20, 16'sd1);
    send_sample(16'sd20, 16'sd20, -16'sd1);
    drain();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_sample(16'sd20, 16'sd20, 16'sd0);

    // Random phases, each under its own register setting.
    phase_scale[3] = $urandom;
    phase_rate[3] = $urandom;
    phase_thr[3] = $urandom;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(REG_SCALE, phase_scale[p]);
      write_reg(REG_RATE, phase_rate[p]);
      write_reg(REG_THRESH, phase_thr[p]);
      quiet = (p == 2);
      for (int n = 0; n < 220; n++) send_sample(rand_count(), rand_count(), rand_step());
    end
    quiet = 1'b0;
    drain();
    repeat (300) @(posedge clk_i);

    $display("Checked %0d poses (%0d straight, %0d arc) over %0d register writes.",
             tracker.checked, tracker.n_straight, tracker.n_arc, cfg_writes);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d", tracker.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d poses outstanding.", tracker.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
